// ===== design/lpga_pkg.sv =====
// lpga_pkg: shared types and constants for the line pid gain autotuner
// no dependencies; imported by line_pid_gain_autotuner, lpga_props, lpga_checker and the testbench
package lpga_pkg;

  localparam int unsigned SENSOR_W  = 12;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PERIOD_FB = 16;
  localparam logic [SENSOR_W-1:0] TOLERANCE = 12'd25;
  localparam logic [2:0] PHASE_IDLE = 3'd6;
  localparam logic [2:0] LAST_TEST  = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_SPACING   = 3'd0,
    CFG_BASE_SPEED     = 3'd1,
    CFG_TICK_PERIOD    = 3'd2,
    CFG_TICK_RATE      = 3'd3,
    CFG_TICKS_PER_TEST = 3'd4,
    CFG_LEARN_RATE     = 3'd5,
    CFG_PROBE_STEP     = 3'd6,
    CFG_ACCURACY       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] left_sense;
    logic [11:0] right_sense;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic [2:0]         phase;
    logic               test_end;
    logic               converged;
    logic signed [31:0] gain_p_out;
    logic signed [31:0] gain_i_out;
    logic signed [31:0] gain_d_out;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
    logic signed [15:0] r;
    if (v > 49'sd32767) r = 16'sh7fff;
    else if (v < -49'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== design/line_pid_gain_autotuner.sv =====
// line_pid_gain_autotuner: line follower pid step with finite-difference gain tuning
// ordinary tick: S_M0 to S_M7, S_FIN and S_OUT, back to S_IDLE; result word loads from S_OUT
// calibrating or converged tick goes straight to S_OUT; end of an odd test adds S_DIV to S_UPD
// one shared 33x33 signed multiplier and a one-bit-per-cycle divider serve these steps
// one word at a time; the output register frees the input side while a result waits
// reset (async, active low) clears all control state and loads register defaults
module line_pid_gain_autotuner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpga_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpga_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpga_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpga_pkg::out_t                out_data_o
);
  import lpga_pkg::*;

  // divider numerator: |total - first_total| shifted up by the fraction bits
  localparam int unsigned NUM_W = 33 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic signed [65:0] BIG_POS = 66'sd70368744177664;  // clamp bound 2^46
  localparam logic signed [65:0] BIG_NEG = -66'sd70368744177664;

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_FIN, S_DIV, S_GRAD, S_MLR, S_UPD, S_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [23:0] half_spacing_q;
  logic [8:0]  base_speed_q;
  logic [15:0] tick_period_q, tick_rate_q, ticks_per_test_q;
  logic [19:0] learn_rate_q, probe_step_q, accuracy_q;

  // tuning state
  logic [SENSOR_W-1:0] dark_ref_q;
  logic                seeded_q, done_q;
  logic signed [31:0]  gain_p_q, gain_i_q, gain_d_q, saved_gain_q, first_total_q;
  logic [15:0]         tick_count_q;
  logic [2:0]          test_index_q, small_grads_q;
  logic signed [31:0]  prev_error_q, integral_q, total_error_q;

  // per-tick working registers
  logic signed [24:0]  err_q;
  logic signed [65:0]  prod_q;
  logic signed [47:0]  dcl_q;
  logic signed [63:0]  acc_q;
  logic signed [15:0]  ld_q, rd_q;
  logic [2:0]          phase_q;
  logic                te_q;

  // divider
  logic [NUM_W-1:0]    num_q;
  logic [19:0]         rem_q;
  logic                neg_q;
  logic [CNT_W-1:0]    cnt_q;
  logic signed [31:0]  grad_q;

  logic                out_valid_q;
  out_t                out_q;

  // shared multiplier operands
  logic signed [32:0]  mul_a, mul_b;

  // combinational helpers
  logic [SENSOR_W-1:0] lmin, dmin, ldiff, rdiff;
  logic signed [24:0]  err_new;
  logic [23:0]         mag;
  logic signed [65:0]  pshift, cshift, dlt;
  logic signed [47:0]  ctl;
  logic [16:0]         tick_next;
  logic [15:0]         limit;
  logic                last;
  logic [19:0]         step;
  logic signed [31:0]  cur_gain;
  logic signed [32:0]  diff33;
  logic [32:0]         diff_mag;
  logic signed [21:0]  trial;
  logic signed [31:0]  grad_sat, gain_new;
  logic [32:0]         grad_mag;
  logic [2:0]          small_new;
  logic                in_acc, out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    lmin    = (in_data_i.left_sense < dark_ref_q) ? in_data_i.left_sense : dark_ref_q;
    dmin    = (in_data_i.right_sense < lmin) ? in_data_i.right_sense : lmin;
    ldiff   = in_data_i.left_sense - dmin;
    rdiff   = in_data_i.right_sense - dmin;
    if (ldiff < TOLERANCE) err_new = -$signed({1'b0, half_spacing_q});
    else if (rdiff < TOLERANCE) err_new = $signed({1'b0, half_spacing_q});
    else err_new = '0;
    mag     = err_q[24] ? 24'(-err_q) : err_q[23:0];
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M0: begin
        mul_a = 33'(err_q);
        mul_b = $signed({17'd0, tick_period_q});
      end
      S_M1: begin
        mul_a = $signed({9'd0, mag});
        mul_b = $signed({17'd0, tick_period_q});
      end
      S_M2: begin
        mul_a = 33'(gain_d_q);
        mul_b = 33'(err_q) - 33'(prev_error_q);
      end
      S_M3: begin
        mul_a = 33'(gain_p_q);
        mul_b = 33'(err_q);
      end
      S_M4: begin
        mul_a = 33'(gain_i_q);
        mul_b = 33'(integral_q);
      end
      S_M5: begin
        mul_a = 33'(dcl_q >>> 24);
        mul_b = $signed({17'd0, tick_rate_q});
      end
      S_M6: begin
        mul_a = $signed({9'd0, dcl_q[23:0]});
        mul_b = $signed({17'd0, tick_rate_q});
      end
      S_MLR: begin
        mul_a = $signed({13'd0, learn_rate_q});
        mul_b = 33'(grad_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    pshift    = prod_q >>> FRAC_BITS;
    cshift    = 66'(acc_q) >>> FRAC_BITS;
    if (cshift > BIG_POS) ctl = 48'(BIG_POS);
    else if (cshift < BIG_NEG) ctl = 48'(BIG_NEG);
    else ctl = cshift[47:0];
    tick_next = {1'b0, tick_count_q} + 17'd1;
    limit     = (ticks_per_test_q == '0) ? 16'd1 : ticks_per_test_q;
    last      = tick_next >= {1'b0, limit};
    step      = (probe_step_q == '0) ? 20'd1 : probe_step_q;
    if (test_index_q < 3'd2) cur_gain = gain_p_q;
    else if (test_index_q < 3'd4) cur_gain = gain_i_q;
    else cur_gain = gain_d_q;
    diff33    = 33'(total_error_q) - 33'(first_total_q);
    diff_mag  = diff33[32] ? 33'(-diff33) : diff33;
    trial     = $signed({1'b0, rem_q, num_q[NUM_W-1]}) - $signed({2'b0, step});
    // quotient sits in num_q once the divider has run; truncation toward zero
    if (neg_q) begin
      if ((num_q[NUM_W-1:32] != '0) || (num_q[31] && (num_q[30:0] != '0)))
        grad_sat = 32'sh80000000;
      else
        grad_sat = 32'(-$signed({1'b0, num_q[31:0]}));
    end else begin
      if (num_q[NUM_W-1:31] != '0) grad_sat = 32'sh7fffffff;
      else grad_sat = $signed(num_q[31:0]);
    end
    grad_mag  = grad_q[31] ? 33'(-33'(grad_q)) : 33'(grad_q);
    dlt       = 66'(saved_gain_q) - pshift;
    gain_new  = sat32(dlt);
    small_new = small_grads_q;
    if (grad_mag < {13'd0, accuracy_q}) small_new[test_index_q[2:1]] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      half_spacing_q   <= '0;
      base_speed_q     <= 9'd100;
      tick_period_q    <= 16'd655;
      tick_rate_q      <= 16'd100;
      ticks_per_test_q <= 16'd500;
      learn_rate_q     <= 20'd6554;
      probe_step_q     <= 20'd6554;
      accuracy_q       <= 20'd6554;
      dark_ref_q       <= '0;
      seeded_q         <= 1'b0;
      done_q           <= 1'b0;
      gain_p_q         <= '0;
      gain_i_q         <= '0;
      gain_d_q         <= '0;
      saved_gain_q     <= '0;
      first_total_q    <= '0;
      tick_count_q     <= '0;
      test_index_q     <= '0;
      small_grads_q    <= '0;
      prev_error_q     <= '0;
      integral_q       <= '0;
      total_error_q    <= '0;
      cnt_q            <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_HALF_SPACING:   half_spacing_q   <= cfg_data_i;
          CFG_BASE_SPEED:     base_speed_q     <= cfg_data_i[8:0];
          CFG_TICK_PERIOD:    tick_period_q    <= cfg_data_i[15:0];
          CFG_TICK_RATE:      tick_rate_q      <= cfg_data_i[15:0];
          CFG_TICKS_PER_TEST: ticks_per_test_q <= cfg_data_i[15:0];
          CFG_LEARN_RATE:     learn_rate_q     <= cfg_data_i[19:0];
          CFG_PROBE_STEP:     probe_step_q     <= cfg_data_i[19:0];
          CFG_ACCURACY:       accuracy_q       <= cfg_data_i[19:0];
          default:            half_spacing_q   <= half_spacing_q;
        endcase
      end
      // a new word lands from S_OUT, otherwise the held word leaves when unstalled
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (done_q || !seeded_q) begin
              // calibrating or frozen: no pid step
              if (!done_q) begin
                dark_ref_q <= SENSOR_W'(({1'b0, in_data_i.left_sense}
                              + {1'b0, in_data_i.right_sense}) >> 1);
                seeded_q   <= 1'b1;
              end
              ld_q    <= '0;
              rd_q    <= '0;
              phase_q <= PHASE_IDLE;
              te_q    <= 1'b0;
              state_q <= S_OUT;
            end else begin
              dark_ref_q <= dmin;
              err_q      <= err_new;
              state_q    <= S_M0;
            end
          end
        end
        S_M0: state_q <= S_M1;
        S_M1: begin
          integral_q <= sat32(66'(integral_q) + (prod_q >>> PERIOD_FB));
          state_q    <= S_M2;
        end
        S_M2: begin
          total_error_q <= sat32(66'(total_error_q) + (prod_q >>> PERIOD_FB));
          state_q       <= S_M3;
        end
        S_M3: begin
          // derivative term clamped before the rate scaling
          if (pshift > BIG_POS) dcl_q <= 48'(BIG_POS);
          else if (pshift < BIG_NEG) dcl_q <= 48'(BIG_NEG);
          else dcl_q <= pshift[47:0];
          state_q <= S_M4;
        end
        S_M4: begin
          acc_q   <= 64'(pshift);
          state_q <= S_M5;
        end
        S_M5: begin
          acc_q   <= acc_q + 64'(pshift);
          state_q <= S_M6;
        end
        S_M6: begin
          acc_q   <= acc_q + 64'(prod_q <<< 24);
          state_q <= S_M7;
        end
        S_M7: begin
          acc_q   <= acc_q + 64'(prod_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          ld_q    <= sat16($signed({40'd0, base_speed_q}) - 49'(ctl));
          rd_q    <= sat16($signed({40'd0, base_speed_q}) + 49'(ctl));
          phase_q <= test_index_q;
          te_q    <= last;
          if (!last) begin
            tick_count_q <= tick_next[15:0];
            prev_error_q <= 32'(err_q);
            state_q      <= S_OUT;
          end else begin
            tick_count_q  <= '0;
            prev_error_q  <= '0;
            integral_q    <= '0;
            total_error_q <= '0;
            if (!test_index_q[0]) begin
              // baseline run done: remember it and probe the gain
              saved_gain_q  <= cur_gain;
              first_total_q <= total_error_q;
              if (test_index_q < 3'd2)
                gain_p_q <= sat32(66'(gain_p_q) + $signed({46'd0, step}));
              else if (test_index_q < 3'd4)
                gain_i_q <= sat32(66'(gain_i_q) + $signed({46'd0, step}));
              else
                gain_d_q <= sat32(66'(gain_d_q) + $signed({46'd0, step}));
              test_index_q <= test_index_q + 3'd1;
              state_q      <= S_OUT;
            end else begin
              num_q   <= {diff_mag, {FRAC_BITS{1'b0}}};
              rem_q   <= '0;
              neg_q   <= diff33[32];
              cnt_q   <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!trial[21]) begin
            rem_q <= trial[19:0];
            num_q <= {num_q[NUM_W-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[18:0], num_q[NUM_W-1]};
            num_q <= {num_q[NUM_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(NUM_W - 1)) state_q <= S_GRAD;
        end
        S_GRAD: begin
          grad_q  <= grad_sat;
          state_q <= S_MLR;
        end
        S_MLR: state_q <= S_UPD;
        S_UPD: begin
          if (test_index_q < 3'd2) gain_p_q <= gain_new;
          else if (test_index_q < 3'd4) gain_i_q <= gain_new;
          else gain_d_q <= gain_new;
          if (test_index_q >= LAST_TEST) begin
            if (small_new == 3'b111) done_q <= 1'b1;
            small_grads_q <= '0;
            test_index_q  <= '0;
          end else begin
            small_grads_q <= small_new;
            test_index_q  <= test_index_q + 3'd1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // shared multiplier with registered product
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q.left_drive  <= ld_q;
      out_q.right_drive <= rd_q;
      out_q.phase       <= phase_q;
      out_q.test_end    <= te_q;
      out_q.converged   <= done_q;
      out_q.gain_p_out  <= gain_p_q;
      out_q.gain_i_out  <= gain_i_q;
      out_q.gain_d_out  <= gain_d_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/lpga_checker.sv =====
// lpga_props: port-level checks for line_pid_gain_autotuner
// depends on lpga_pkg; bound to the top level below
module lpga_props (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [lpga_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [lpga_pkg::CFG_W-1:0]     cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input lpga_pkg::in_t                  in_data_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input lpga_pkg::out_t                 out_data_o
);
  import lpga_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  // a converged word past the converging tick carries no drive and the idle phase
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.converged && !out_data_o.test_end |->
      out_data_o.phase == PHASE_IDLE
      && out_data_o.left_drive == '0 && out_data_o.right_drive == '0)
    else $error("converged word not frozen");

  // a test end only comes from a real test phase
  a_tend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.test_end |-> out_data_o.phase <= LAST_TEST)
    else $error("test end outside a test");

  // phase code never beyond idle
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.phase <= PHASE_IDLE)
    else $error("bad phase");

endmodule

bind line_pid_gain_autotuner lpga_props u_lpga_props (.*);

// ===== bench/lpga_checker.sv =====
// lpga_checker: watches the sensor, config and drive channels of the autotuner
// keeps its own copy of the pid and tuning state and compares every result word
// depends on lpga_pkg for the word types and register indexes
module lpga_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  lpga_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [lpga_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  lpga_pkg::in_t              in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  lpga_pkg::out_t             out_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpga_pkg::*;

  localparam int FB = 16;
  localparam longint CLAMP46 = longint'(1) <<< 46;

  logic [23:0] half_spacing;
  logic [8:0]  base_speed;
  logic [15:0] tick_period, tick_rate, ticks_per_test;
  logic [19:0] learn_rate, probe_step, accuracy;

  int          dark_ref;
  logic        seeded, done;
  int          gain [3];
  int          saved_gain, first_total, prev_error, integral, total_error;
  int unsigned tick_count, test_index;
  logic [2:0]  small_grads;

  out_t        drive_words [$];
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = drive_words.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int clip32(longint v);
    return int'(clip(v, -64'sd2147483648, 64'sd2147483647));
  endfunction

  // finishes a test run: probe the gain on even runs, gradient step on odd runs
  task automatic finish_run();
    int     k;
    longint step, grad, mag;
    k    = test_index / 2;
    step = (probe_step == 0) ? 1 : longint'(probe_step);
    if (test_index[0] == 1'b0) begin
      saved_gain  = gain[k];
      first_total = total_error;
      gain[k]     = clip32(longint'(gain[k]) + step);
    end else begin
      grad    = clip32(((longint'(total_error) - longint'(first_total)) * 65536) / step);
      mag     = grad < 0 ? -grad : grad;
      gain[k] = clip32(longint'(saved_gain) - ((longint'(learn_rate) * grad) >>> FB));
      if (mag < longint'(accuracy)) small_grads[k] = 1'b1;
    end
    if (test_index >= LAST_TEST) begin
      if (small_grads == 3'b111) done = 1'b1;
      small_grads = '0;
      test_index  = 0;
    end else begin
      test_index++;
    end
    tick_count  = 0;
    integral    = 0;
    prev_error  = 0;
    total_error = 0;
  endtask

  // one sensor tick: queues the drive word the block should produce
  task automatic predict_tick(input in_t w);
    int     l, r;
    longint err, mag, d, ctl, ld, rd, limit;
    logic [2:0] ph;
    logic   last;
    out_t   o;
    l = w.left_sense;
    r = w.right_sense;
    ld = 0; rd = 0; ph = PHASE_IDLE; last = 1'b0;
    if (done || !seeded) begin
      if (!done) begin
        dark_ref = (l + r) / 2;
        seeded   = 1'b1;
      end
    end else begin
      if (l < dark_ref) dark_ref = l;
      if (r < dark_ref) dark_ref = r;
      if (l - dark_ref < int'(TOLERANCE))      err = -longint'(half_spacing);
      else if (r - dark_ref < int'(TOLERANCE)) err = longint'(half_spacing);
      else                                     err = 0;
      mag = err < 0 ? -err : err;
      integral    = clip32(longint'(integral)
                    + ((err * longint'(tick_period)) >>> PERIOD_FB));
      total_error = clip32(longint'(total_error)
                    + ((mag * longint'(tick_period)) >>> PERIOD_FB));
      d   = (longint'(gain[2]) * (err - longint'(prev_error))) >>> FB;
      d   = clip(d, -CLAMP46, CLAMP46) * longint'(tick_rate);
      ctl = ((longint'(gain[0]) * err) >>> FB)
          + ((longint'(gain[1]) * longint'(integral)) >>> FB) + d;
      ctl = clip(ctl >>> FB, -CLAMP46, CLAMP46);
      prev_error = int'(err);
      ld = clip(longint'(base_speed) - ctl, -32768, 32767);
      rd = clip(longint'(base_speed) + ctl, -32768, 32767);
      ph    = test_index[2:0];
      limit = (ticks_per_test == 0) ? 1 : ticks_per_test;
      tick_count++;
      last = tick_count >= limit;
      if (last) finish_run();
    end
    o.left_drive  = ld[15:0];
    o.right_drive = rd[15:0];
    o.phase       = ph;
    o.test_end    = last;
    o.converged   = done;
    o.gain_p_out  = gain[0];
    o.gain_i_out  = gain[1];
    o.gain_d_out  = gain[2];
    drive_words.push_back(o);
  endtask

  task automatic report(string field, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e, a;
    if (!rst_ni) begin
      half_spacing = '0; base_speed = 9'd100; tick_period = 16'd655; tick_rate = 16'd100;
      ticks_per_test = 16'd500; learn_rate = 20'd6554; probe_step = 20'd6554;
      accuracy = 20'd6554;
      dark_ref = 0; seeded = 1'b0; done = 1'b0;
      gain[0] = 0; gain[1] = 0; gain[2] = 0;
      saved_gain = 0; first_total = 0; prev_error = 0; integral = 0; total_error = 0;
      tick_count = 0; test_index = 0; small_grads = '0;
      drive_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HALF_SPACING:   half_spacing   = cfg_data_i[23:0];
          CFG_BASE_SPEED:     base_speed     = cfg_data_i[8:0];
          CFG_TICK_PERIOD:    tick_period    = cfg_data_i[15:0];
          CFG_TICK_RATE:      tick_rate      = cfg_data_i[15:0];
          CFG_TICKS_PER_TEST: ticks_per_test = cfg_data_i[15:0];
          CFG_LEARN_RATE:     learn_rate     = cfg_data_i[19:0];
          CFG_PROBE_STEP:     probe_step     = cfg_data_i[19:0];
          CFG_ACCURACY:       accuracy       = cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_tick(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        a = out_data_i;
        if (drive_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected drive word %h", $realtime, a);
        end else begin
          e = drive_words.pop_front();
          if (a.left_drive !== e.left_drive) report("left_drive", e.left_drive, a.left_drive);
          if (a.right_drive !== e.right_drive)
            report("right_drive", e.right_drive, a.right_drive);
          if (a.phase !== e.phase) report("phase", e.phase, a.phase);
          if (a.test_end !== e.test_end) report("test_end", e.test_end, a.test_end);
          if (a.converged !== e.converged) report("converged", e.converged, a.converged);
          if (a.gain_p_out !== e.gain_p_out) report("gain_p", e.gain_p_out, a.gain_p_out);
          if (a.gain_i_out !== e.gain_i_out) report("gain_i", e.gain_i_out, a.gain_i_out);
          if (a.gain_d_out !== e.gain_d_out) report("gain_d", e.gain_d_out, a.gain_d_out);
        end
      end
    end
  end

endmodule

// ===== bench/tb_line_pid_gain_autotuner.sv =====
// tb_line_pid_gain_autotuner: sensor stimulus, register phases and verdict
// depends on lpga_pkg, line_pid_gain_autotuner and lpga_checker
module tb_line_pid_gain_autotuner;
  timeunit 1ns;
  timeprecision 1ps;
  import lpga_pkg::*;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  cfg_idx_e       cfg_idx_i = CFG_HALF_SPACING;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  in_t            in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  out_t           out_data_o;

  int             fail_count, pending;
  logic           jittery = 1'b1;   // gaps and stalls on or off for a stretch
  int             stall_left = 0;

  always #2 clk_i = ~clk_i;

  line_pid_gain_autotuner i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  lpga_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (jittery && $urandom_range(7) == 0) begin
      stall_left  <= ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // random gap, then hold the word until the block takes it
  task automatic send_word(input logic [11:0] l, input logic [11:0] r);
    int gap;
    gap = 0;
    if (jittery && $urandom_range(2) == 0)
      gap = ($urandom_range(11) == 0) ? $urandom_range(50, 10) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end
    @(posedge clk_i);
    in_valid_i            <= 1'b1;
    in_data_i.left_sense  <= l;
    in_data_i.right_sense <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // a reading near the dark level about half the time so every error case turns up
  function automatic logic [11:0] pick_reading();
    return ($urandom_range(1) == 0) ? 12'($urandom_range(40)) : 12'($urandom_range(4095));
  endfunction

  // registers only change with nothing in flight; allow for a slow gradient pass
  task automatic load_regs(input logic [23:0] hs, input logic [8:0] bs,
                           input logic [15:0] tp, input logic [15:0] tr,
                           input logic [15:0] tpt, input logic [19:0] lr,
                           input logic [19:0] ps, input logic [19:0] acc);
    logic [23:0] vals [8];
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    vals = '{hs, 24'(bs), 24'(tp), 24'(tr), 24'(tpt), 24'(lr), 24'(ps), 24'(acc)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_ticks(input int n);
    for (int i = 0; i < n; i++) send_word(pick_reading(), pick_reading());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // high extremes, two ticks per test so a round closes inside the directed part
    load_regs(24'hffffff, 9'd500, 16'hffff, 16'hffff, 16'd2, 20'hfffff, 20'hfffff, 20'd0);
    jittery = 1'b0;
    send_word(12'd4095, 12'd4095);   // seeds the dark reference
    send_word(12'd4095, 12'd4095);   // both at the dark reference: left wins
    send_word(12'd0,    12'd4095);   // left on the line
    send_word(12'd4095, 12'd0);      // right on the line
    send_word(12'd24,   12'd4095);   // just inside tolerance
    send_word(12'd25,   12'd4095);   // just outside tolerance
    send_word(12'd4095, 12'd24);
    send_word(12'd4095, 12'd25);
    send_word(12'd0,    12'd0);      // both dark: left wins
    send_word(12'd2730, 12'd1365);
    for (int i = 0; i < 12; i++) send_word(12'd0, 12'd4095);   // push gains to saturation
    jittery = 1'b1;
    random_ticks(250);

    // low extremes, including zero tick count and zero probe step
    load_regs(24'd0, 9'd0, 16'd1, 16'd1, 16'd0, 20'd0, 20'd0, 20'd0);
    random_ticks(200);

    // random settings with short test runs; gradients never count as small here
    for (int p = 0; p < 5; p++) begin
      jittery = (p != 2);
      load_regs(24'($urandom_range(24'hffffff)), 9'($urandom_range(500)),
                16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                16'($urandom_range(6, 1)), 20'($urandom_range(20'hfffff)),
                20'($urandom_range(20'hfffff, 1)), 20'd0);
      random_ticks(280);
    end
    jittery = 1'b1;

    // moderate gains, then let tuning settle: zero spacing gives zero gradients
    load_regs(24'h008000, 9'd100, 16'd655, 16'd100, 16'd3, 20'd6554, 20'd6554, 20'd0);
    random_ticks(100);
    load_regs(24'd0, 9'd100, 16'd655, 16'd100, 16'd1, 20'd6554, 20'd6554, 20'hfffff);
    random_ticks(60);                // converges within two rounds, then frozen

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lpga_pkg.sv
design/line_pid_gain_autotuner.sv
design/lpga_checker.sv
bench/lpga_checker.sv
bench/tb_line_pid_gain_autotuner.sv
